>>> rtl/md5_stream_hash_assert.svh
// Assertion macros for the md5_stream_hash checker.
// Uses clk and rst_n of the module that expands them.
`ifndef MD5_STREAM_HASH_ASSERT_SVH
`define MD5_STREAM_HASH_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MD5SH_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("md5_stream_hash assertion failed");

// Consequent checked in the cycle after the antecedent.
`define MD5SH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("md5_stream_hash assertion failed");

`endif

>>> rtl/md5sh_pkg.sv
// Shared types, constants, microprogram and round functions for md5_stream_hash.
// No dependencies.
package md5sh_pkg;

    localparam int DATA_W   = 8;
    localparam int ACT_W    = 2;
    localparam int WORD_W   = 32;
    localparam int DIGEST_W = 128;
    localparam int MSG_WORDS = 16;
    localparam int PTR_W    = 6;
    localparam int RND_W    = 6;
    localparam int PC_W     = 5;

    localparam logic [ACT_W-1:0] ACT_APPEND        = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND_FINISH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FINISH        = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RESERVED      = 2'd3;

    localparam logic [WORD_W-1:0] H0_INIT = 32'h67452301;
    localparam logic [WORD_W-1:0] H1_INIT = 32'hefcdab89;
    localparam logic [WORD_W-1:0] H2_INIT = 32'h98badcfe;
    localparam logic [WORD_W-1:0] H3_INIT = 32'h10325476;

    localparam logic [DATA_W-1:0] PAD_MARK    = 8'h80;
    localparam logic [PTR_W-1:0]  LEN_POS     = 6'd56;
    localparam logic [PTR_W-1:0]  BLOCK_LAST  = 6'd63;
    localparam logic [RND_W-1:0]  RND_LAST    = 6'd63;
    localparam logic [3:0]        LEN_WORD_LO = 4'd14;
    localparam logic [3:0]        LEN_WORD_HI = 4'd15;

    typedef logic [PC_W-1:0] upc_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_APPEND,
        OP_PAD80,
        OP_PADZ,
        OP_LEN_LO,
        OP_LEN_HI,
        OP_CMP_INIT,
        OP_CMP_ROUND,
        OP_CMP_FINAL,
        OP_DIGEST
    } dp_op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_JUMP,
        SEQ_CALL,
        SEQ_RET
    } seq_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NOT_ACCEPT,
        C_ACT_RSVD,
        C_ACT_FIN,
        C_ACT_APP,
        C_PTR_NE_LAST,
        C_PTR_EQ_LEN,
        C_RND_NE_LAST,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        dp_op_t op;
        seq_t   seq;
        cond_t  cond;
        upc_t   target;
        logic   ready;
    } uword_t;

    typedef struct packed {
        dp_op_t op;
        logic   capture;
    } dp_ctl_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             ptr_last;
        logic             ptr_len;
        logic             rnd_last;
        logic             out_busy;
    } dp_stat_t;

    // microprogram entry points
    localparam upc_t UA_WAIT    = 5'd0;
    localparam upc_t UA_APP_END = 5'd5;
    localparam upc_t UA_FIN     = 5'd6;
    localparam upc_t UA_ZLOOP   = 5'd8;
    localparam upc_t UA_LEN     = 5'd12;
    localparam upc_t UA_OUTWAIT = 5'd15;
    localparam upc_t UA_COMP    = 5'd17;
    localparam upc_t UA_ROUND   = 5'd18;

    function automatic uword_t uw(dp_op_t op, seq_t seq, cond_t cond, upc_t tgt, logic rdy);
        uword_t w;
        w.op     = op;
        w.seq    = seq;
        w.cond   = cond;
        w.target = tgt;
        w.ready  = rdy;
        return w;
    endfunction

    function automatic uword_t ucode_rom(upc_t pc);
        uword_t w;
        case (pc)
            5'd0:  w = uw(OP_NOP,       SEQ_JUMP, C_NOT_ACCEPT,  UA_WAIT,    1'b1);
            5'd1:  w = uw(OP_NOP,       SEQ_JUMP, C_ACT_RSVD,    UA_WAIT,    1'b0);
            5'd2:  w = uw(OP_NOP,       SEQ_JUMP, C_ACT_FIN,     UA_FIN,     1'b0);
            5'd3:  w = uw(OP_APPEND,    SEQ_JUMP, C_PTR_NE_LAST, UA_APP_END, 1'b0);
            5'd4:  w = uw(OP_NOP,       SEQ_CALL, C_ALWAYS,      UA_COMP,    1'b0);
            5'd5:  w = uw(OP_NOP,       SEQ_JUMP, C_ACT_APP,     UA_WAIT,    1'b0);
            5'd6:  w = uw(OP_PAD80,     SEQ_JUMP, C_PTR_NE_LAST, UA_ZLOOP,   1'b0);
            5'd7:  w = uw(OP_NOP,       SEQ_CALL, C_ALWAYS,      UA_COMP,    1'b0);
            5'd8:  w = uw(OP_NOP,       SEQ_JUMP, C_PTR_EQ_LEN,  UA_LEN,     1'b0);
            5'd9:  w = uw(OP_PADZ,      SEQ_JUMP, C_PTR_NE_LAST, UA_ZLOOP,   1'b0);
            5'd10: w = uw(OP_NOP,       SEQ_CALL, C_ALWAYS,      UA_COMP,    1'b0);
            5'd11: w = uw(OP_NOP,       SEQ_JUMP, C_ALWAYS,      UA_ZLOOP,   1'b0);
            5'd12: w = uw(OP_LEN_LO,    SEQ_NEXT, C_ALWAYS,      UA_WAIT,    1'b0);
            5'd13: w = uw(OP_LEN_HI,    SEQ_NEXT, C_ALWAYS,      UA_WAIT,    1'b0);
            5'd14: w = uw(OP_NOP,       SEQ_CALL, C_ALWAYS,      UA_COMP,    1'b0);
            5'd15: w = uw(OP_NOP,       SEQ_JUMP, C_OUT_BUSY,    UA_OUTWAIT, 1'b0);
            5'd16: w = uw(OP_DIGEST,    SEQ_JUMP, C_ALWAYS,      UA_WAIT,    1'b0);
            5'd17: w = uw(OP_CMP_INIT,  SEQ_NEXT, C_ALWAYS,      UA_WAIT,    1'b0);
            5'd18: w = uw(OP_CMP_ROUND, SEQ_JUMP, C_RND_NE_LAST, UA_ROUND,   1'b0);
            5'd19: w = uw(OP_CMP_FINAL, SEQ_RET,  C_ALWAYS,      UA_WAIT,    1'b0);
            default: w = uw(OP_NOP,     SEQ_JUMP, C_ALWAYS,      UA_WAIT,    1'b0);
        endcase
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(logic [RND_W-1:0] i);
        logic [WORD_W-1:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amt(logic [RND_W-1:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word used by round i; i[5:4] picks the formula, applied to i[3:0] mod 16
    function automatic logic [3:0] msg_idx(logic [RND_W-1:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = i[3:0] * 4'd5 + 4'd1;
            2'd2: g = i[3:0] * 4'd3 + 4'd5;
            2'd3: g = i[3:0] * 4'd7;
            default: g = i[3:0];
        endcase
        return g;
    endfunction

    function automatic logic [WORD_W-1:0] round_f(logic [RND_W-1:0] i,
                                                  logic [WORD_W-1:0] b,
                                                  logic [WORD_W-1:0] c,
                                                  logic [WORD_W-1:0] d);
        logic [WORD_W-1:0] f;
        case (i[5:4])
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (b & d) | (c & ~d);
            2'd2: f = b ^ c ^ d;
            2'd3: f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    function automatic logic [WORD_W-1:0] rotl32(logic [WORD_W-1:0] v, logic [4:0] n);
        logic [2*WORD_W-1:0] t;
        t = {v, v} << n;
        return t[2*WORD_W-1:WORD_W];
    endfunction

endpackage

>>> rtl/md5sh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module md5sh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/md5sh_useq.sv
// Microcode sequencer: step counter, return link and branch condition logic.
// Depends on md5sh_pkg (control word ROM, condition codes).
module md5sh_useq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  md5sh_pkg::dp_stat_t stat,
    output logic                in_ready,
    output md5sh_pkg::dp_ctl_t  ctl
);
    import md5sh_pkg::*;

    upc_t   pc_reg, pc_next;
    upc_t   link_reg, link_next;
    uword_t uword;
    logic   accept;
    logic   cond_hit;

    assign uword  = ucode_rom(pc_reg);
    assign accept = uword.ready & in_valid;

    always_comb
    begin
        case (uword.cond)
            C_ALWAYS:      cond_hit = 1'b1;
            C_NOT_ACCEPT:  cond_hit = !accept;
            C_ACT_RSVD:    cond_hit = (stat.act == ACT_RESERVED);
            C_ACT_FIN:     cond_hit = (stat.act == ACT_FINISH);
            C_ACT_APP:     cond_hit = (stat.act == ACT_APPEND);
            C_PTR_NE_LAST: cond_hit = !stat.ptr_last;
            C_PTR_EQ_LEN:  cond_hit = stat.ptr_len;
            C_RND_NE_LAST: cond_hit = !stat.rnd_last;
            C_OUT_BUSY:    cond_hit = stat.out_busy;
            default:       cond_hit = 1'b0;
        endcase
    end

    // next step
    always_comb
    begin
        pc_next   = pc_reg + upc_t'(1);
        link_next = link_reg;
        case (uword.seq)
            SEQ_NEXT: pc_next = pc_reg + upc_t'(1);
            SEQ_JUMP:
            begin
                if (cond_hit)
                begin
                    pc_next = uword.target;
                end
            end
            SEQ_CALL:
            begin
                pc_next   = uword.target;
                link_next = pc_reg + upc_t'(1);
            end
            SEQ_RET:  pc_next = link_reg;
            default:  pc_next = UA_WAIT;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready    = uword.ready;
        ctl.op      = uword.op;
        ctl.capture = accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= UA_WAIT;
            link_reg <= UA_WAIT;
        end
        else
        begin
            pc_reg   <= pc_next;
            link_reg <= link_next;
        end
    end

endmodule

>>> rtl/md5sh_dpath.sv
// MD5 datapath: byte packing, block word store, round unit, chaining state, output register.
// Depends on md5sh_pkg and md5sh_ram.
module md5sh_dpath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  md5sh_pkg::dp_ctl_t                    ctl,
    input  logic [md5sh_pkg::ACT_W-1:0]           in_act,
    input  logic [md5sh_pkg::DATA_W-1:0]          in_byte,
    input  logic                                  out_ready,
    output md5sh_pkg::dp_stat_t                   stat,
    output logic                                  out_valid,
    output logic [md5sh_pkg::DIGEST_W-1:0]        out_data
);
    import md5sh_pkg::*;

    logic [ACT_W-1:0]    act_reg, act_next;
    logic [DATA_W-1:0]   byte_reg, byte_next;
    logic [WORD_W-1:0]   chain_reg [4];
    logic [WORD_W-1:0]   chain_next [4];
    logic [WORD_W-1:0]   wa_reg, wb_reg, wc_reg, wd_reg;
    logic [WORD_W-1:0]   wa_next, wb_next, wc_next, wd_next;
    logic [RND_W-1:0]    rnd_reg, rnd_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [63:0]         total_reg, total_next;
    logic [WORD_W-1:0]   wbuf_reg, wbuf_next;
    logic [DIGEST_W-1:0] dig_reg, dig_next;
    logic                ov_reg, ov_next;

    logic [DATA_W-1:0]   ins_byte;
    logic [WORD_W-1:0]   word_ins;
    logic [63:0]         bit_count;
    logic                ram_we;
    logic [3:0]          ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [3:0]          ram_raddr;
    logic [WORD_W-1:0]   msg_word;
    logic [WORD_W-1:0]   rsum;
    logic                byte_op;

    md5sh_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MSG_WORDS)
    ) u_blk (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (msg_word)
    );

    assign bit_count = {total_reg[60:0], 3'b000};
    assign byte_op   = ctl.op inside {OP_APPEND, OP_PAD80, OP_PADZ};

    always_comb
    begin
        case (ctl.op)
            OP_PAD80: ins_byte = PAD_MARK;
            OP_PADZ:  ins_byte = '0;
            default:  ins_byte = byte_reg;
        endcase
        word_ins = wbuf_reg;
        case (ptr_reg[1:0])
            2'd0:    word_ins[7:0]   = ins_byte;
            2'd1:    word_ins[15:8]  = ins_byte;
            2'd2:    word_ins[23:16] = ins_byte;
            2'd3:    word_ins[31:24] = ins_byte;
            default: word_ins[7:0]   = ins_byte;
        endcase
    end

    // block store write port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg[5:2];
        ram_wdata = word_ins;
        case (ctl.op)
            OP_LEN_LO:
            begin
                ram_we    = 1'b1;
                ram_waddr = LEN_WORD_LO;
                ram_wdata = bit_count[31:0];
            end
            OP_LEN_HI:
            begin
                ram_we    = 1'b1;
                ram_waddr = LEN_WORD_HI;
                ram_wdata = bit_count[63:32];
            end
            default: ram_we = byte_op && (ptr_reg[1:0] == 2'd3);
        endcase
    end

    // read address comes from rnd_next, so the registered read data lines up with the round that consumes it
    assign ram_raddr = msg_idx(rnd_next);
    assign rsum      = wa_reg + round_f(rnd_reg, wb_reg, wc_reg, wd_reg)
                       + round_k(rnd_reg) + msg_word;

    always_comb
    begin
        act_next   = act_reg;
        byte_next  = byte_reg;
        chain_next = chain_reg;
        wa_next    = wa_reg;
        wb_next    = wb_reg;
        wc_next    = wc_reg;
        wd_next    = wd_reg;
        rnd_next   = rnd_reg;
        ptr_next   = ptr_reg;
        total_next = total_reg;
        wbuf_next  = wbuf_reg;
        dig_next   = dig_reg;
        ov_next    = ov_reg & ~out_ready;

        if (ctl.capture)
        begin
            act_next  = in_act;
            byte_next = in_byte;
        end

        if (byte_op)
        begin
            wbuf_next = word_ins;
            ptr_next  = ptr_reg + PTR_W'(1);
        end

        case (ctl.op)
            OP_APPEND:   total_next = total_reg + 64'd1;
            OP_CMP_INIT:
            begin
                wa_next  = chain_reg[0];
                wb_next  = chain_reg[1];
                wc_next  = chain_reg[2];
                wd_next  = chain_reg[3];
                rnd_next = '0;
            end
            OP_CMP_ROUND:
            begin
                wa_next  = wd_reg;
                wd_next  = wc_reg;
                wc_next  = wb_reg;
                wb_next  = wb_reg + rotl32(rsum, rot_amt(rnd_reg));
                rnd_next = rnd_reg + RND_W'(1);
            end
            OP_CMP_FINAL:
            begin
                chain_next[0] = chain_reg[0] + wa_reg;
                chain_next[1] = chain_reg[1] + wb_reg;
                chain_next[2] = chain_reg[2] + wc_reg;
                chain_next[3] = chain_reg[3] + wd_reg;
            end
            OP_DIGEST:
            begin
                dig_next      = {chain_reg[3], chain_reg[2], chain_reg[1], chain_reg[0]};
                ov_next       = 1'b1;
                chain_next[0] = H0_INIT;
                chain_next[1] = H1_INIT;
                chain_next[2] = H2_INIT;
                chain_next[3] = H3_INIT;
                total_next    = '0;
                ptr_next      = '0;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        stat.act      = act_reg;
        stat.ptr_last = (ptr_reg == BLOCK_LAST);
        stat.ptr_len  = (ptr_reg == LEN_POS);
        stat.rnd_last = (rnd_reg == RND_LAST);
        stat.out_busy = ov_reg & ~out_ready;
    end

    assign out_valid = ov_reg;
    assign out_data  = dig_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= H0_INIT;
            chain_reg[1] <= H1_INIT;
            chain_reg[2] <= H2_INIT;
            chain_reg[3] <= H3_INIT;
            rnd_reg      <= '0;
            ptr_reg      <= '0;
            total_reg    <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            chain_reg <= chain_next;
            rnd_reg   <= rnd_next;
            ptr_reg   <= ptr_next;
            total_reg <= total_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        byte_reg <= byte_next;
        wa_reg   <= wa_next;
        wb_reg   <= wb_next;
        wc_reg   <= wc_next;
        wd_reg   <= wd_next;
        wbuf_reg <= wbuf_next;
        dig_reg  <= dig_next;
    end

endmodule

>>> rtl/md5_stream_hash.sv
// MD5 stream hash, one byte per transfer. Microcoded: a byte append packs the byte into the
// block store, then compresses when it completes a 64-byte block (one round per cycle in the
// round unit). A finish appends the 0x80 mark, zero fills up to the length field, writes the
// bit count and compresses one or two blocks until the digest is valid; append and finish
// appends its byte first. The byte side is ready again when the digest shows.
// Reset (rst_n low, asynchronous) loads the MD5 initial chaining words and clears the count.
module md5_stream_hash (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [md5sh_pkg::DATA_W-1:0]         s_axis_tdata,   // [7:0] data_byte
    input  logic [md5sh_pkg::ACT_W-1:0]          s_axis_tuser,   // [1:0] action
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [md5sh_pkg::DIGEST_W-1:0]       m_axis_tdata    // [63:0] digest_low,
                                                                 // [127:64] digest_high
);
    import md5sh_pkg::*;

    dp_ctl_t  ctl;
    dp_stat_t stat;

    md5sh_useq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .ctl      (ctl)
    );

    md5sh_dpath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .in_act    (s_axis_tuser),
        .in_byte   (s_axis_tdata),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

endmodule

>>> rtl/md5sh_checker.sv
// Port-level assertions for md5_stream_hash, bound to the top level.
// Depends on md5sh_pkg and md5_stream_hash_assert.svh.
`include "md5_stream_hash_assert.svh"

module md5sh_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [md5sh_pkg::DIGEST_W-1:0] m_axis_tdata
);

    logic in_xfer;
    logic out_xfer;
    logic out_stall;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_xfer  = m_axis_tvalid && m_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // stalled digest holds
    `MD5SH_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
    // one item in flight: the sequencer leaves the wait step after a transfer
    `MD5SH_ASSERT_NEXT(a_in_one_at_a_time, in_xfer, !s_axis_tready)
    // valid drops after a digest is taken; digests never come back to back
    `MD5SH_ASSERT_NEXT(a_out_spacing, out_xfer, !m_axis_tvalid)
    // a new digest never shows right after an input transfer
    `MD5SH_ASSERT_NEXT(a_no_instant_digest, in_xfer, !$rose(m_axis_tvalid))

endmodule

bind md5_stream_hash md5sh_checker u_chk (.*);
